[src/ttess_pkg.sv]
// Shared types, constants and helpers for the triangle grid tessellator.
// Depends on nothing; used by every module under src.
`default_nettype none

package ttess_pkg;

  localparam int LEVEL_MAX   = 6;
  localparam int LEVEL_WIDTH = 3;
  localparam int COORD_WIDTH = 16;
  localparam int INDEX_WIDTH = 12;

  // b-a and c-b need one more bit than a coordinate
  localparam int DIFF_WIDTH = COORD_WIDTH + 1;
  // a + j*dab + i*dbc stays within three times the coordinate range
  localparam int ACC_WIDTH  = COORD_WIDTH + 3;

  // Reciprocal divide: q = (|d| * ceil(2^K/lv)) >> K is exact for |d| < 2^C
  // and lv <= 6 when 2^K >= 5 * 2^C.
  localparam int RECIP_SHIFT = COORD_WIDTH + 3;
  localparam int RECIP_WIDTH = RECIP_SHIFT + 1;
  localparam int PROD_WIDTH  = COORD_WIDTH + RECIP_WIDTH;

  localparam logic [63:0] RECIP_ONE = 64'd1 << RECIP_SHIFT;
  localparam logic [RECIP_WIDTH-1:0] RECIP_1 = RECIP_WIDTH'(RECIP_ONE);
  localparam logic [RECIP_WIDTH-1:0] RECIP_2 = RECIP_WIDTH'((RECIP_ONE + 64'd1) / 64'd2);
  localparam logic [RECIP_WIDTH-1:0] RECIP_3 = RECIP_WIDTH'((RECIP_ONE + 64'd2) / 64'd3);
  localparam logic [RECIP_WIDTH-1:0] RECIP_4 = RECIP_WIDTH'((RECIP_ONE + 64'd3) / 64'd4);
  localparam logic [RECIP_WIDTH-1:0] RECIP_5 = RECIP_WIDTH'((RECIP_ONE + 64'd4) / 64'd5);
  localparam logic [RECIP_WIDTH-1:0] RECIP_6 = RECIP_WIDTH'((RECIP_ONE + 64'd5) / 64'd6);

  // Edge deltas: tags 0..2 are b-a x/y/z, tags 3..5 are c-b x/y/z.
  localparam int NUM_DELTAS = 6;
  localparam int TAG_WIDTH  = 3;
  localparam logic [TAG_WIDTH-1:0] TAG_DAB_X = 3'd0;
  localparam logic [TAG_WIDTH-1:0] TAG_DAB_Y = 3'd1;
  localparam logic [TAG_WIDTH-1:0] TAG_DAB_Z = 3'd2;
  localparam logic [TAG_WIDTH-1:0] TAG_DBC_X = 3'd3;
  localparam logic [TAG_WIDTH-1:0] TAG_DBC_Y = 3'd4;
  localparam logic [TAG_WIDTH-1:0] TAG_DBC_Z = 3'd5;

  localparam int IN_DATA_WIDTH  = ((9 * COORD_WIDTH) + 7) / 8 * 8;
  localparam int OUT_FIELD_BITS = 3 * COORD_WIDTH + 3 * INDEX_WIDTH;
  localparam int OUT_DATA_WIDTH = (OUT_FIELD_BITS + 7) / 8 * 8;

  localparam logic CMD_TESSELLATE = 1'b0;
  localparam logic CMD_RESTART    = 1'b1;
  localparam logic KIND_VERTEX    = 1'b0;
  localparam logic KIND_TRIANGLE  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_VERTEX,
    ST_TRIANGLE
  } state_e;

  typedef struct packed {
    logic                         valid;
    logic [TAG_WIDTH-1:0]         tag;
    logic signed [DIFF_WIDTH-1:0] diff;
  } div_req_t;

  typedef struct packed {
    logic                         valid;
    logic [TAG_WIDTH-1:0]         tag;
    logic signed [DIFF_WIDTH-1:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic start;
    logic step;
  } tri_ctrl_t;

  function automatic logic [LEVEL_WIDTH-1:0] clamp_level(input logic [LEVEL_WIDTH-1:0] lv);
    logic [LEVEL_WIDTH-1:0] res;
    if (lv == '0) begin
      res = LEVEL_WIDTH'(1);
    end else if (lv > LEVEL_WIDTH'(LEVEL_MAX)) begin
      res = LEVEL_WIDTH'(LEVEL_MAX);
    end else begin
      res = lv;
    end
    return res;
  endfunction

  function automatic logic [RECIP_WIDTH-1:0] recip_of(input logic [LEVEL_WIDTH-1:0] lv);
    logic [RECIP_WIDTH-1:0] res;
    unique case (lv)
      3'd2:    res = RECIP_2;
      3'd3:    res = RECIP_3;
      3'd4:    res = RECIP_4;
      3'd5:    res = RECIP_5;
      3'd6:    res = RECIP_6;
      default: res = RECIP_1;
    endcase
    return res;
  endfunction

  function automatic logic [COORD_WIDTH-1:0] sat_coord(input logic signed [ACC_WIDTH-1:0] v);
    logic [COORD_WIDTH-1:0] res;
    logic                   fits;
    fits = (v[ACC_WIDTH-1:COORD_WIDTH-1] == '0) || (v[ACC_WIDTH-1:COORD_WIDTH-1] == '1);
    if (fits) begin
      res = v[COORD_WIDTH-1:0];
    end else if (v[ACC_WIDTH-1]) begin
      res = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    end else begin
      res = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[src/triangle_grid_tessellator.sv]
// Top level of the triangle grid tessellator: sequencer, vertex walker,
// output register. Depends on ttess_pkg, ttess_div and ttess_tri.
//
//  channel   dir  handshake                tdata / tuser / tlast
//  s_axis    in   tvalid/tready            9 corner coords / command
//  m_axis    out  tvalid/tready            position + indices / kind / last
//  cfg       in   we (no back-pressure)    subdivision_level
//
// A request is accepted, its edge deltas go through the divider, and
// then records follow at one per cycle while m_axis does not stall:
// (L+1)(L+2)/2 vertices and then L*L triangles at level L.
// A restart request produces no record.
// Reset clears the sequencer, the vertex counter and the level (to 1).
// m_axis stalls hold the walker in place; s_axis is not ready until the
// last record of a request has been loaded into the output register.
`default_nettype none

module triangle_grid_tessellator (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  // configuration
  input  wire logic                                  cfg_we_i,
  input  wire logic [ttess_pkg::LEVEL_WIDTH-1:0]     cfg_wdata_i,   // subdivision_level
  // request stream
  input  wire logic                                  s_axis_tvalid_i,
  output logic                                       s_axis_tready_o,
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z (lowest first)
  input  wire logic [ttess_pkg::IN_DATA_WIDTH-1:0]   s_axis_tdata_i,
  input  wire logic                                  s_axis_tuser_i, // command
  // record stream
  output logic                                       m_axis_tvalid_o,
  input  wire logic                                  m_axis_tready_i,
  // pos_x, pos_y, pos_z, index_first, index_second, index_third, zero pad
  output logic [ttess_pkg::OUT_DATA_WIDTH-1:0]       m_axis_tdata_o,
  output logic                                       m_axis_tuser_o, // record_kind
  output logic                                       m_axis_tlast_o  // last_record
);

  localparam int C = ttess_pkg::COORD_WIDTH;
  localparam int I = ttess_pkg::INDEX_WIDTH;

  ttess_pkg::state_e state_q, state_d;

  logic [ttess_pkg::LEVEL_WIDTH-1:0] cfg_level_q;   // raw register
  logic [ttess_pkg::LEVEL_WIDTH-1:0] lv_q;          // clamped copy for this request
  logic [I-1:0]                      vcnt_q;        // running vertex counter
  logic [I-1:0]                      base_q;

  logic signed [C-1:0] a_q [3];
  logic signed [C-1:0] b_q [3];
  logic signed [C-1:0] c_q [3];
  logic signed [ttess_pkg::DIFF_WIDTH-1:0] dab_q [3];
  logic signed [ttess_pkg::DIFF_WIDTH-1:0] dbc_q [3];

  logic [ttess_pkg::TAG_WIDTH-1:0] feed_cnt_q;

  // vertex walker: r_q is the row start, p_q the current grid point
  logic signed [ttess_pkg::ACC_WIDTH-1:0] r_q [3];
  logic signed [ttess_pkg::ACC_WIDTH-1:0] p_q [3];
  logic signed [ttess_pkg::ACC_WIDTH-1:0] r_next [3];
  logic signed [ttess_pkg::ACC_WIDTH-1:0] p_next [3];
  logic [ttess_pkg::LEVEL_WIDTH-1:0]      vi_q, vj_q;

  logic m_valid_q;
  logic [ttess_pkg::OUT_DATA_WIDTH-1:0] m_data_q;
  logic m_kind_q, m_last_q;

  logic s_ready, s_accept, out_free, feed, vtx_load, tri_load, vtx_end;
  logic signed [ttess_pkg::DIFF_WIDTH-1:0] feed_diff;

  ttess_pkg::div_req_t  div_req;
  ttess_pkg::div_rsp_t  div_rsp;
  ttess_pkg::tri_ctrl_t tri_ctrl;
  logic [I-1:0] tri_idx0, tri_idx1, tri_idx2;
  logic         tri_last;

  assign s_accept = s_axis_tvalid_i && s_ready;
  assign out_free = !m_valid_q || m_axis_tready_i;
  assign vtx_end  = (vj_q == lv_q) && (vi_q == vj_q);

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ttess_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    s_ready  = 1'b0;
    feed     = 1'b0;
    vtx_load = 1'b0;
    tri_load = 1'b0;
    tri_ctrl = '0;
    unique case (state_q)
      ttess_pkg::ST_IDLE: begin
        s_ready = 1'b1;
        if (s_axis_tvalid_i && (s_axis_tuser_i == ttess_pkg::CMD_TESSELLATE)) begin
          state_d = ttess_pkg::ST_DIVIDE;
        end
      end
      ttess_pkg::ST_DIVIDE: begin
        feed = (feed_cnt_q < ttess_pkg::TAG_WIDTH'(ttess_pkg::NUM_DELTAS));
        if (div_rsp.valid && (div_rsp.tag == ttess_pkg::TAG_DBC_Z)) begin
          state_d = ttess_pkg::ST_VERTEX;
        end
      end
      ttess_pkg::ST_VERTEX: begin
        if (out_free) begin
          vtx_load = 1'b1;
          if (vtx_end) begin
            tri_ctrl.start = 1'b1;
            state_d        = ttess_pkg::ST_TRIANGLE;
          end
        end
      end
      ttess_pkg::ST_TRIANGLE: begin
        if (out_free) begin
          tri_load      = 1'b1;
          tri_ctrl.step = 1'b1;
          if (tri_last) begin
            state_d = ttess_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = ttess_pkg::ST_IDLE;
    endcase
  end

  assign s_axis_tready_o = s_ready;

  // ------------------------------------------------------ config and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_level_q <= ttess_pkg::LEVEL_WIDTH'(1);
      vcnt_q      <= '0;
      feed_cnt_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        cfg_level_q <= cfg_wdata_i;
      end
      if (s_accept && (s_axis_tuser_i == ttess_pkg::CMD_RESTART)) begin
        vcnt_q <= '0;
      end else if (vtx_load) begin
        vcnt_q <= vcnt_q + I'(1);
      end
      if (s_accept) begin
        feed_cnt_q <= '0;
      end else if (feed) begin
        feed_cnt_q <= feed_cnt_q + ttess_pkg::TAG_WIDTH'(1);
      end
    end
  end

  // corners and the clamped level are captured with the request
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      lv_q   <= ttess_pkg::clamp_level(cfg_level_q);
      base_q <= vcnt_q;
      for (int k = 0; k < 3; k++) begin
        a_q[k] <= s_axis_tdata_i[k*C +: C];
        b_q[k] <= s_axis_tdata_i[(k+3)*C +: C];
        c_q[k] <= s_axis_tdata_i[(k+6)*C +: C];
      end
    end
  end

  // ------------------------------------------------------------ edge deltas
  always_comb begin
    unique case (feed_cnt_q)
      ttess_pkg::TAG_DAB_X: feed_diff = {b_q[0][C-1], b_q[0]} - {a_q[0][C-1], a_q[0]};
      ttess_pkg::TAG_DAB_Y: feed_diff = {b_q[1][C-1], b_q[1]} - {a_q[1][C-1], a_q[1]};
      ttess_pkg::TAG_DAB_Z: feed_diff = {b_q[2][C-1], b_q[2]} - {a_q[2][C-1], a_q[2]};
      ttess_pkg::TAG_DBC_X: feed_diff = {c_q[0][C-1], c_q[0]} - {b_q[0][C-1], b_q[0]};
      ttess_pkg::TAG_DBC_Y: feed_diff = {c_q[1][C-1], c_q[1]} - {b_q[1][C-1], b_q[1]};
      default:              feed_diff = {c_q[2][C-1], c_q[2]} - {b_q[2][C-1], b_q[2]};
    endcase
    div_req.valid = feed;
    div_req.tag   = feed_cnt_q;
    div_req.diff  = feed_diff;
  end

  ttess_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .level_i (lv_q),
    .req_i   (div_req),
    .rsp_o   (div_rsp)
  );

  always_ff @(posedge clk_i) begin
    if (div_rsp.valid) begin
      unique case (div_rsp.tag)
        ttess_pkg::TAG_DAB_X: dab_q[0] <= div_rsp.quot;
        ttess_pkg::TAG_DAB_Y: dab_q[1] <= div_rsp.quot;
        ttess_pkg::TAG_DAB_Z: dab_q[2] <= div_rsp.quot;
        ttess_pkg::TAG_DBC_X: dbc_q[0] <= div_rsp.quot;
        ttess_pkg::TAG_DBC_Y: dbc_q[1] <= div_rsp.quot;
        default:              dbc_q[2] <= div_rsp.quot;
      endcase
    end
  end

  // ---------------------------------------------------------- vertex walker
  // next column adds dbc; a new row starts from the previous row start + dab
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      r_next[k] = r_q[k] + ttess_pkg::ACC_WIDTH'(dab_q[k]);
      p_next[k] = (vi_q < vj_q) ? (p_q[k] + ttess_pkg::ACC_WIDTH'(dbc_q[k])) : r_next[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ttess_pkg::ST_DIVIDE) begin
      vi_q <= '0;
      vj_q <= '0;
      for (int k = 0; k < 3; k++) begin
        r_q[k] <= ttess_pkg::ACC_WIDTH'(a_q[k]);
        p_q[k] <= ttess_pkg::ACC_WIDTH'(a_q[k]);
      end
    end else if (vtx_load) begin
      for (int k = 0; k < 3; k++) begin
        p_q[k] <= p_next[k];
      end
      if (vi_q < vj_q) begin
        vi_q <= vi_q + ttess_pkg::LEVEL_WIDTH'(1);
      end else begin
        vi_q <= '0;
        vj_q <= vj_q + ttess_pkg::LEVEL_WIDTH'(1);
        for (int k = 0; k < 3; k++) begin
          r_q[k] <= r_next[k];
        end
      end
    end
  end

  ttess_tri u_tri (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (tri_ctrl),
    .base_i  (base_q),
    .level_i (lv_q),
    .idx0_o  (tri_idx0),
    .idx1_o  (tri_idx1),
    .idx2_o  (tri_idx2),
    .last_o  (tri_last)
  );

  // --------------------------------------------------------- output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (vtx_load || tri_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vtx_load) begin
      m_kind_q <= ttess_pkg::KIND_VERTEX;
      m_last_q <= 1'b0;
      m_data_q <= ttess_pkg::OUT_DATA_WIDTH'({ttess_pkg::sat_coord(p_q[2]),
                                              ttess_pkg::sat_coord(p_q[1]),
                                              ttess_pkg::sat_coord(p_q[0])});
    end else if (tri_load) begin
      m_kind_q <= ttess_pkg::KIND_TRIANGLE;
      m_last_q <= tri_last;
      m_data_q <= ttess_pkg::OUT_DATA_WIDTH'({tri_idx2, tri_idx1, tri_idx0,
                                              {(3*C){1'b0}}});
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_kind_q;
  assign m_axis_tlast_o  = m_last_q;

  // -------------------------------------------------------------- assertions
  a_walker_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ttess_pkg::ST_VERTEX) |-> ((vi_q <= vj_q) && (vj_q <= lv_q)))
    else $error("vertex walker left the triangular grid");

  a_div_only_in_divide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.valid |-> (state_q == ttess_pkg::ST_DIVIDE))
    else $error("divider result outside the delta phase");

  a_last_is_triangle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tlast_o) |-> (m_axis_tuser_o == ttess_pkg::KIND_TRIANGLE))
    else $error("final record is not a triangle record");

  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_accept && (s_axis_tuser_i == ttess_pkg::CMD_RESTART)) |=> (vcnt_q == '0))
    else $error("restart did not clear the vertex counter");

  a_done_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tri_load && tri_last) |=> (state_q == ttess_pkg::ST_IDLE))
    else $error("sequencer did not return to idle after the final triangle");

endmodule

`default_nettype wire

[src/ttess_div.sv]
// Shared two-stage divider: signed difference / level by reciprocal multiply.
// Depends on ttess_pkg.
`default_nettype none

module ttess_div (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic [ttess_pkg::LEVEL_WIDTH-1:0]    level_i,
  input  wire ttess_pkg::div_req_t                  req_i,
  output ttess_pkg::div_rsp_t                       rsp_o
);

  logic                                  neg;
  logic [ttess_pkg::COORD_WIDTH-1:0]     mag;
  logic [ttess_pkg::DIFF_WIDTH-1:0]      diff_abs;
  logic [ttess_pkg::PROD_WIDTH-1:0]      prod_d;

  logic [ttess_pkg::PROD_WIDTH-1:0]      prod_q;
  logic                                  neg_q;
  logic [ttess_pkg::TAG_WIDTH-1:0]       tag_q;
  logic                                  vld_q;

  logic [ttess_pkg::COORD_WIDTH-1:0]     quot_mag;
  logic signed [ttess_pkg::DIFF_WIDTH-1:0] quot_d;
  logic                                  rsp_valid_q;
  logic [ttess_pkg::TAG_WIDTH-1:0]       rsp_tag_q;
  logic signed [ttess_pkg::DIFF_WIDTH-1:0] rsp_quot_q;

  // stage 1: magnitude times reciprocal
  always_comb begin
    neg      = req_i.diff[ttess_pkg::DIFF_WIDTH-1];
    diff_abs = neg ? (~req_i.diff + 1'b1) : req_i.diff;
    mag      = diff_abs[ttess_pkg::COORD_WIDTH-1:0];
    prod_d   = ttess_pkg::PROD_WIDTH'(mag) *
               ttess_pkg::PROD_WIDTH'(ttess_pkg::recip_of(level_i));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    neg_q  <= neg;
    tag_q  <= req_i.tag;
  end

  // stage 2: shift out the fraction, restore the sign (truncates toward zero)
  always_comb begin
    quot_mag = prod_q[ttess_pkg::RECIP_SHIFT +: ttess_pkg::COORD_WIDTH];
    quot_d   = neg_q ? -$signed({1'b0, quot_mag}) : $signed({1'b0, quot_mag});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_tag_q  <= tag_q;
    rsp_quot_q <= quot_d;
  end

  always_comb begin
    rsp_o.valid = rsp_valid_q;
    rsp_o.tag   = rsp_tag_q;
    rsp_o.quot  = rsp_quot_q;
  end

endmodule

`default_nettype wire

[src/ttess_tri.sv]
// Triangle index walker: row/column counters that produce index triples.
// Depends on ttess_pkg.
`default_nettype none

module ttess_tri (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire ttess_pkg::tri_ctrl_t                 ctrl_i,
  input  wire logic [ttess_pkg::INDEX_WIDTH-1:0]    base_i,
  input  wire logic [ttess_pkg::LEVEL_WIDTH-1:0]    level_i,
  output logic [ttess_pkg::INDEX_WIDTH-1:0]         idx0_o,
  output logic [ttess_pkg::INDEX_WIDTH-1:0]         idx1_o,
  output logic [ttess_pkg::INDEX_WIDTH-1:0]         idx2_o,
  output logic                                      last_o
);

  logic [ttess_pkg::INDEX_WIDTH-1:0] row0_q, row1_q;
  logic [ttess_pkg::LEVEL_WIDTH-1:0] col_q, row_q;
  logic                              half_q;
  logic [ttess_pkg::INDEX_WIDTH-1:0] col_ext;

  assign col_ext = ttess_pkg::INDEX_WIDTH'(col_q);

  // half 0: upward triangle, half 1: downward triangle between it and the next
  always_comb begin
    idx0_o = row0_q + col_ext;
    if (!half_q) begin
      idx1_o = row1_q + col_ext;
      idx2_o = row1_q + col_ext + ttess_pkg::INDEX_WIDTH'(1);
    end else begin
      idx1_o = row1_q + col_ext + ttess_pkg::INDEX_WIDTH'(1);
      idx2_o = row0_q + col_ext + ttess_pkg::INDEX_WIDTH'(1);
    end
    last_o = !half_q && (col_q == row_q) &&
             (row_q == (level_i - ttess_pkg::LEVEL_WIDTH'(1)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row0_q <= '0;
      row1_q <= '0;
      col_q  <= '0;
      row_q  <= '0;
      half_q <= 1'b0;
    end else if (ctrl_i.start) begin
      row0_q <= base_i;
      row1_q <= base_i + ttess_pkg::INDEX_WIDTH'(1);
      col_q  <= '0;
      row_q  <= '0;
      half_q <= 1'b0;
    end else if (ctrl_i.step) begin
      priority if (!half_q && (col_q < row_q)) begin
        half_q <= 1'b1;
      end else if (col_q < row_q) begin
        half_q <= 1'b0;
        col_q  <= col_q + ttess_pkg::LEVEL_WIDTH'(1);
      end else begin
        half_q <= 1'b0;
        col_q  <= '0;
        row_q  <= row_q + ttess_pkg::LEVEL_WIDTH'(1);
        row0_q <= row1_q;
        row1_q <= row1_q + ttess_pkg::INDEX_WIDTH'(row_q) + ttess_pkg::INDEX_WIDTH'(2);
      end
    end
  end

endmodule

`default_nettype wire
